// ===== hw/rtl/mtx4_pkg.sv =====
package mtx4_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAT_DIM    = 4;
   localparam int N_ELEM     = MAT_DIM * MAT_DIM;
   localparam int IDX_W      = $clog2(N_ELEM);
   localparam int DIM_W      = $clog2(MAT_DIM);
   localparam int PROD_W     = 2 * DATA_WIDTH;
   // four products summed: two guard bits
   localparam int ACC_W      = PROD_W + 2;

   typedef logic [1:0]                   opcode_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [DIM_W-1:0]             dim_type;
   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [ACC_W-1:0]      acc_type;

   localparam opcode_type OP_LOAD_A  = 2'd0;
   localparam opcode_type OP_LOAD_B  = 2'd1;
   localparam opcode_type OP_COMPUTE = 2'd2;

   localparam elem_type ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

// ===== hw/rtl/mtx4_ram.sv =====
module mtx4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/matrix4x4_multiply_core.sv =====
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_ready  | opcode, element_index, element_value
// rsp     | out | rsp_valid / rsp_ready  | result_index, result_value, saturated, last
//
// A load beat writes one RAM entry. A compute beat runs 16 elements, each
// as four reads from each RAM through one shared multiplier and
// accumulator, then shift and saturate. The elements run one after
// another; the next one starts its reads when the previous is finalized.
// req_ready is low while a compute runs. A result held on rsp delays the
// next element's finalize. Reset clears the per-entry valid bits, so both
// matrices read as zero until written.
module matrix4x4_multiply_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mtx4_pkg::opcode_type     req_opcode,
   input  mtx4_pkg::idx_type        req_element_index,
   input  mtx4_pkg::elem_type       req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mtx4_pkg::idx_type        rsp_result_index,
   output mtx4_pkg::elem_type       rsp_result_value,
   output logic                     rsp_saturated,
   output logic                     rsp_last
);

   import mtx4_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic             issuing_ff, issuing_in;
   idx_type          e_ff, e_in;
   dim_type          k_ff, k_in;

   logic [N_ELEM-1:0] a_vld_ff, b_vld_ff;

   logic             s1_vld_ff, s1_first_ff, s1_last_ff;
   logic             a_rv_ff, b_rv_ff;
   logic             s2_vld_ff, s2_first_ff, s2_last_ff;
   prod_type         prod_ff;
   acc_type          acc_ff, acc_in;
   logic             acc_done_ff, acc_done_in;

   logic             rsp_valid_ff, rsp_valid_in;
   idx_type          rsp_index_ff;
   elem_type         rsp_value_ff;
   logic             rsp_sat_ff, rsp_last_ff;

   logic             req_fire, wr_a, wr_b, start, fin_fire;
   idx_type          rd_addr_a, rd_addr_b;
   logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
   elem_type         op_a, op_b;
   acc_type          shifted;
   logic             in_range;
   elem_type         sat_value;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_fire  = req_valid && req_ready;
      wr_a      = req_fire && (req_opcode == OP_LOAD_A);
      wr_b      = req_fire && (req_opcode == OP_LOAD_B);
      start     = req_fire && (req_opcode == OP_COMPUTE);
      // A[k*4+row] and B[col*4+k]
      rd_addr_a = {k_ff, e_ff[DIM_W-1:0]};
      rd_addr_b = {e_ff[IDX_W-1:DIM_W], k_ff};
      fin_fire  = acc_done_ff && (!rsp_valid_ff || rsp_ready);
   end

   mtx4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(N_ELEM)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_en   (issuing_ff),
      .rd_addr (rd_addr_a),
      .rd_data (rdata_a)
   );

   mtx4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(N_ELEM)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_en   (issuing_ff),
      .rd_addr (rd_addr_b),
      .rd_data (rdata_b)
   );

   // never-written entries read as zero
   always_comb begin
      op_a = a_rv_ff ? elem_type'(rdata_a) : '0;
      op_b = b_rv_ff ? elem_type'(rdata_b) : '0;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      issuing_in = issuing_ff;
      e_in       = e_ff;
      k_in       = k_ff;
      if (start) begin
         state_in   = ST_RUN;
         issuing_in = 1'b1;
         e_in       = '0;
         k_in       = '0;
      end else begin
         if (issuing_ff) begin
            k_in = k_ff + dim_type'(1);
            if (k_ff == dim_type'(MAT_DIM - 1)) begin
               issuing_in = 1'b0;
            end
         end
         if (fin_fire) begin
            if (e_ff == idx_type'(N_ELEM - 1)) begin
               state_in = ST_IDLE;
            end else begin
               e_in       = e_ff + idx_type'(1);
               k_in       = '0;
               issuing_in = 1'b1;
            end
         end
      end
   end

   // accumulate and finalize
   always_comb begin
      acc_in      = acc_ff;
      acc_done_in = acc_done_ff;
      if (fin_fire) begin
         acc_done_in = 1'b0;
      end
      if (s2_vld_ff) begin
         acc_in = (s2_first_ff ? acc_type'(0) : acc_ff) + acc_type'(prod_ff);
         if (s2_last_ff) begin
            acc_done_in = 1'b1;
         end
      end

      shifted  = acc_ff >>> FRAC_BITS;
      in_range = (&shifted[ACC_W-1:DATA_WIDTH-1]) || !(|shifted[ACC_W-1:DATA_WIDTH-1]);
      if (in_range) begin
         sat_value = shifted[DATA_WIDTH-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_value = ELEM_MIN;
      end else begin
         sat_value = ELEM_MAX;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         e_ff         <= '0;
         k_ff         <= '0;
         a_vld_ff     <= '0;
         b_vld_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         e_ff         <= e_in;
         k_ff         <= k_in;
         if (wr_a) begin
            a_vld_ff[req_element_index] <= 1'b1;
         end
         if (wr_b) begin
            b_vld_ff[req_element_index] <= 1'b1;
         end
         s1_vld_ff    <= issuing_ff;
         s2_vld_ff    <= s1_vld_ff;
         acc_done_ff  <= acc_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload pipeline, no reset
   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == dim_type'(0));
      s1_last_ff  <= (k_ff == dim_type'(MAT_DIM - 1));
      a_rv_ff     <= a_vld_ff[rd_addr_a];
      b_rv_ff     <= b_vld_ff[rd_addr_b];
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= op_a * op_b;
      acc_ff      <= acc_in;
      if (fin_fire) begin
         rsp_index_ff <= e_ff;
         rsp_value_ff <= sat_value;
         rsp_sat_ff   <= !in_range;
         rsp_last_ff  <= (e_ff == idx_type'(N_ELEM - 1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
